>>> rtl/espc_pkg.sv
// Shared types, widths, register indexes and helpers for the espresso controller.
`timescale 1ns / 1ps

package espc_pkg;

	// Sample and integrator sizing
	localparam int SAMPLE_BITS   = 12;
	localparam int INTEGRAL_BITS = 24;

	// Derived arithmetic widths
	localparam int GAIN_W  = 10;
	localparam int SGAIN_W = GAIN_W + 1;
	localparam int ERR_W   = SAMPLE_BITS + 1;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int SUM_W   = ((INTEGRAL_BITS > ERR_W) ? INTEGRAL_BITS : ERR_W) + 1;
	localparam int P_W     = SGAIN_W + ERR_W;
	localparam int I_W     = SGAIN_W + INTEGRAL_BITS;
	localparam int D_W     = SGAIN_W + DIFF_W;
	localparam int ACC_W   = ((I_W > D_W) ? I_W : D_W) + 2;
	localparam int Q_SHIFT = 8;

	localparam logic signed [ACC_W-1:0] Q_ROUND = ACC_W'((1 << Q_SHIFT) - 1);

	localparam logic signed [SUM_W-1:0] INT_MAX =
		SUM_W'((64'sd1 <<< (INTEGRAL_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] INT_MIN =
		SUM_W'(-(64'sd1 <<< (INTEGRAL_BITS - 1)));

	// Duty range
	localparam int DUTY_W = 7;
	localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);

	// Operating modes
	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HEATING = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READY   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BREWING = 2'd3;

	// Configuration port
	localparam int CFG_W   = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_TARGET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_TARGET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_KP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_KI      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_KD      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_KP     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_KI     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_KD     = 3'd7;

	localparam logic [SAMPLE_BITS-1:0] RST_TEMP_TARGET  = SAMPLE_BITS'(3500);
	localparam logic [SAMPLE_BITS-1:0] RST_PRESS_TARGET = SAMPLE_BITS'(3000);
	localparam logic [GAIN_W-1:0] RST_TEMP_KP  = GAIN_W'(128);
	localparam logic [GAIN_W-1:0] RST_TEMP_KI  = GAIN_W'(51);
	localparam logic [GAIN_W-1:0] RST_TEMP_KD  = GAIN_W'(77);
	localparam logic [GAIN_W-1:0] RST_PRESS_KP = GAIN_W'(154);
	localparam logic [GAIN_W-1:0] RST_PRESS_KI = GAIN_W'(38);
	localparam logic [GAIN_W-1:0] RST_PRESS_KD = GAIN_W'(102);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] temp_target;
		logic [SAMPLE_BITS-1:0] press_target;
		logic [GAIN_W-1:0]      temp_kp;
		logic [GAIN_W-1:0]      temp_ki;
		logic [GAIN_W-1:0]      temp_kd;
		logic [GAIN_W-1:0]      press_kp;
		logic [GAIN_W-1:0]      press_ki;
		logic [GAIN_W-1:0]      press_kd;
	} cfg_t;

	typedef struct packed {
		logic signed [INTEGRAL_BITS-1:0] integral;
		logic signed [ERR_W-1:0]         last_err;
		logic [DUTY_W-1:0]               duty;
	} pid_res_t;

	// Divide a signed Q8 product by 256, truncating toward zero
	function automatic logic signed [ACC_W-1:0] tz_q8(input logic signed [ACC_W-1:0] p);
		logic signed [ACC_W-1:0] adj;
		adj = p + (p[ACC_W-1] ? Q_ROUND : '0);
		return adj >>> Q_SHIFT;
	endfunction

endpackage

>>> rtl/espc_cfg.sv
// Configuration register file for setpoints and loop gains.
`timescale 1ns / 1ps

module espc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [espc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [espc_pkg::CFG_W-1:0]      cfg_data,
	output espc_pkg::cfg_t                  cfg
);

	espc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_target  <= espc_pkg::RST_TEMP_TARGET;
			cfg_q.press_target <= espc_pkg::RST_PRESS_TARGET;
			cfg_q.temp_kp      <= espc_pkg::RST_TEMP_KP;
			cfg_q.temp_ki      <= espc_pkg::RST_TEMP_KI;
			cfg_q.temp_kd      <= espc_pkg::RST_TEMP_KD;
			cfg_q.press_kp     <= espc_pkg::RST_PRESS_KP;
			cfg_q.press_ki     <= espc_pkg::RST_PRESS_KI;
			cfg_q.press_kd     <= espc_pkg::RST_PRESS_KD;
		end else if (cfg_we) begin
			// drop bits above each register's width
			case (cfg_index)
				espc_pkg::REG_TEMP_TARGET: begin
					cfg_q.temp_target <= cfg_data[espc_pkg::SAMPLE_BITS-1:0];
				end
				espc_pkg::REG_PRESS_TARGET: begin
					cfg_q.press_target <= cfg_data[espc_pkg::SAMPLE_BITS-1:0];
				end
				espc_pkg::REG_TEMP_KP: begin
					cfg_q.temp_kp <= cfg_data[espc_pkg::GAIN_W-1:0];
				end
				espc_pkg::REG_TEMP_KI: begin
					cfg_q.temp_ki <= cfg_data[espc_pkg::GAIN_W-1:0];
				end
				espc_pkg::REG_TEMP_KD: begin
					cfg_q.temp_kd <= cfg_data[espc_pkg::GAIN_W-1:0];
				end
				espc_pkg::REG_PRESS_KP: begin
					cfg_q.press_kp <= cfg_data[espc_pkg::GAIN_W-1:0];
				end
				espc_pkg::REG_PRESS_KI: begin
					cfg_q.press_ki <= cfg_data[espc_pkg::GAIN_W-1:0];
				end
				espc_pkg::REG_PRESS_KD: begin
					cfg_q.press_kd <= cfg_data[espc_pkg::GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/espc_pid.sv
// One PID step: error, saturating integral, three Q2.8 terms and duty clamp.
`timescale 1ns / 1ps

module espc_pid (
	input  logic [espc_pkg::SAMPLE_BITS-1:0]          target,
	input  logic [espc_pkg::SAMPLE_BITS-1:0]          sample,
	input  logic [espc_pkg::GAIN_W-1:0]               kp,
	input  logic [espc_pkg::GAIN_W-1:0]               ki,
	input  logic [espc_pkg::GAIN_W-1:0]               kd,
	input  logic signed [espc_pkg::INTEGRAL_BITS-1:0] integral,
	input  logic signed [espc_pkg::ERR_W-1:0]         last_err,
	output espc_pkg::pid_res_t                        res
);

	logic signed [espc_pkg::ERR_W-1:0]         err;
	logic signed [espc_pkg::SUM_W-1:0]         sum;
	logic signed [espc_pkg::INTEGRAL_BITS-1:0] new_int;
	logic signed [espc_pkg::DIFF_W-1:0]        diff;
	logic signed [espc_pkg::P_W-1:0]           p_prod;
	logic signed [espc_pkg::I_W-1:0]           i_prod;
	logic signed [espc_pkg::D_W-1:0]           d_prod;
	logic signed [espc_pkg::ACC_W-1:0]         u;

	always_comb begin
		err = $signed({1'b0, target}) - $signed({1'b0, sample});
		sum = espc_pkg::SUM_W'(integral) + espc_pkg::SUM_W'(err);
		if (sum > espc_pkg::INT_MAX) begin
			new_int = espc_pkg::INT_MAX[espc_pkg::INTEGRAL_BITS-1:0];
		end else if (sum < espc_pkg::INT_MIN) begin
			new_int = espc_pkg::INT_MIN[espc_pkg::INTEGRAL_BITS-1:0];
		end else begin
			new_int = sum[espc_pkg::INTEGRAL_BITS-1:0];
		end
		diff = espc_pkg::DIFF_W'(err) - espc_pkg::DIFF_W'(last_err);

		p_prod = $signed({1'b0, kp}) * err;
		i_prod = $signed({1'b0, ki}) * new_int;
		d_prod = $signed({1'b0, kd}) * diff;

		u = espc_pkg::tz_q8(espc_pkg::ACC_W'(p_prod))
		  + espc_pkg::tz_q8(espc_pkg::ACC_W'(i_prod))
		  + espc_pkg::tz_q8(espc_pkg::ACC_W'(d_prod));

		res.integral = new_int;
		res.last_err = err;
		if (u < 0) begin
			res.duty = '0;
		end else if (u > $signed(espc_pkg::ACC_W'(espc_pkg::DUTY_MAX))) begin
			res.duty = espc_pkg::DUTY_MAX;
		end else begin
			res.duty = u[espc_pkg::DUTY_W-1:0];
		end
	end

endmodule

>>> rtl/espresso_mode_and_pid_controller.sv
// Top level of the espresso mode controller with temperature and pressure PID loops.
`timescale 1ns / 1ps

// Espresso machine controller. Each transfer on the input channel is one control
// tick carrying the power and brew button levels and one temperature and one
// pressure sample; each tick yields exactly one transfer on the output channel
// with the heater and pump duties (percent, 0..100), the two LEDs and the mode
// after the tick (0 off, 1 heating, 2 ready, 3 brewing). A button counts as
// pressed on the tick its level falls from 1 to 0. The power button toggles
// OFF/on, heating moves to READY once the temperature reaches its setpoint, and
// the brew button toggles READY/BREWING. The temperature loop runs on every tick
// that starts outside OFF, and the heater reads zero on any tick that starts or
// ends in OFF; the pressure loop runs only on ticks that start and end in
// BREWING. Throughput is one tick per clock while results are taken: a tick is
// held in the input register while both PID datapaths (three multipliers each)
// and the mode logic evaluate, then lands in the output register. The input
// side keeps accepting while a result waits to be taken, stalling only when
// both stages are full.
// Setpoints and gains are written through the configuration port (index 0..7,
// no read-back) and must only be changed while no tick is in flight.

module espresso_mode_and_pid_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  onoff_button,
	input  logic                                  brew_button,
	input  logic [espc_pkg::SAMPLE_BITS-1:0]      temp_sample,
	input  logic [espc_pkg::SAMPLE_BITS-1:0]      press_sample,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [espc_pkg::DUTY_W-1:0]           heater_duty,
	output logic [espc_pkg::DUTY_W-1:0]           pump_duty,
	output logic                                  power_led,
	output logic                                  ready_lamp,
	output logic [espc_pkg::MODE_W-1:0]           mode,
	// configuration
	input  logic                                  cfg_we,
	input  logic [espc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [espc_pkg::CFG_W-1:0]            cfg_data
);

	espc_pkg::cfg_t cfg;

	// Input register stage
	logic                                valid_s1;
	logic                                onoff_s1;
	logic                                brew_s1;
	logic [espc_pkg::SAMPLE_BITS-1:0]    temp_s1;
	logic [espc_pkg::SAMPLE_BITS-1:0]    press_s1;

	// Controller state
	logic [espc_pkg::MODE_W-1:0]         mode_q;
	logic                                onoff_held_q;
	logic                                brew_held_q;
	logic signed [espc_pkg::INTEGRAL_BITS-1:0] temp_int_q;
	logic signed [espc_pkg::ERR_W-1:0]   temp_err_q;
	logic signed [espc_pkg::INTEGRAL_BITS-1:0] press_int_q;
	logic signed [espc_pkg::ERR_W-1:0]   press_err_q;
	logic [espc_pkg::DUTY_W-1:0]         pump_q;

	// Output register
	logic                                out_valid_q;
	logic [espc_pkg::DUTY_W-1:0]         heater_out_q;
	logic [espc_pkg::DUTY_W-1:0]         pump_out_q;
	logic [espc_pkg::MODE_W-1:0]         mode_out_q;

	// Tick evaluation
	logic                                advance;
	logic                                onoff_press;
	logic                                brew_press;
	logic [espc_pkg::MODE_W-1:0]         next_mode;
	logic                                temp_run;
	logic                                press_run;
	logic                                leave_brew;
	logic [espc_pkg::DUTY_W-1:0]         heater_val;
	logic [espc_pkg::DUTY_W-1:0]         pump_val;
	espc_pkg::pid_res_t                  temp_res;
	espc_pkg::pid_res_t                  press_res;

	espc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	espc_pid u_temp_pid (
		.target   (cfg.temp_target),
		.sample   (temp_s1),
		.kp       (cfg.temp_kp),
		.ki       (cfg.temp_ki),
		.kd       (cfg.temp_kd),
		.integral (temp_int_q),
		.last_err (temp_err_q),
		.res      (temp_res)
	);

	espc_pid u_press_pid (
		.target   (cfg.press_target),
		.sample   (press_s1),
		.kp       (cfg.press_kp),
		.ki       (cfg.press_ki),
		.kd       (cfg.press_kd),
		.integral (press_int_q),
		.last_err (press_err_q),
		.res      (press_res)
	);

	// Advance the held tick whenever the output register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Release detection on the held levels from the previous tick
	assign onoff_press = onoff_held_q && !onoff_s1;
	assign brew_press  = brew_held_q && !brew_s1;

	always_comb begin
		next_mode = mode_q;
		case (mode_q)
			espc_pkg::MODE_OFF: begin
				if (onoff_press) next_mode = espc_pkg::MODE_HEATING;
			end
			espc_pkg::MODE_HEATING: begin
				if (onoff_press) next_mode = espc_pkg::MODE_OFF;
				else if (temp_s1 >= cfg.temp_target) next_mode = espc_pkg::MODE_READY;
			end
			espc_pkg::MODE_READY: begin
				if (onoff_press) next_mode = espc_pkg::MODE_OFF;
				else if (brew_press) next_mode = espc_pkg::MODE_BREWING;
			end
			espc_pkg::MODE_BREWING: begin
				if (onoff_press) next_mode = espc_pkg::MODE_OFF;
				else if (brew_press) next_mode = espc_pkg::MODE_READY;
			end
			default: begin
				next_mode = mode_q;
			end
		endcase
	end

	// Temperature loop runs on any tick that starts switched on; the heater is
	// held at zero on the turn-on tick and on any tick that ends in OFF.
	assign temp_run   = (mode_q != espc_pkg::MODE_OFF);
	assign heater_val = (temp_run && (next_mode != espc_pkg::MODE_OFF)) ?
	                    temp_res.duty : '0;

	// Pressure loop only while brewing throughout the tick; leaving brewing zeroes the pump
	assign press_run  = (mode_q == espc_pkg::MODE_BREWING) &&
	                    (next_mode == espc_pkg::MODE_BREWING);
	assign leave_brew = (mode_q == espc_pkg::MODE_BREWING) &&
	                    (next_mode != espc_pkg::MODE_BREWING);
	assign pump_val   = press_run ? press_res.duty : (leave_brew ? '0 : pump_q);

	// Input register: take a new transfer whenever the stage is free or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			onoff_s1 <= onoff_button;
			brew_s1  <= brew_button;
			temp_s1  <= temp_sample;
			press_s1 <= press_sample;
		end
	end

	// Controller state: commit the tick as it moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= espc_pkg::MODE_OFF;
			onoff_held_q <= 1'b0;
			brew_held_q  <= 1'b0;
			temp_int_q   <= '0;
			temp_err_q   <= '0;
			press_int_q  <= '0;
			press_err_q  <= '0;
			pump_q       <= '0;
		end else if (advance) begin
			mode_q       <= next_mode;
			onoff_held_q <= onoff_s1;
			brew_held_q  <= brew_s1;
			pump_q       <= pump_val;
			if (temp_run) begin
				temp_int_q <= temp_res.integral;
				temp_err_q <= temp_res.last_err;
			end
			if (press_run) begin
				press_int_q <= press_res.integral;
				press_err_q <= press_res.last_err;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			heater_out_q <= heater_val;
			pump_out_q   <= pump_val;
			mode_out_q   <= next_mode;
		end
	end

	assign out_valid   = out_valid_q;
	assign heater_duty = heater_out_q;
	assign pump_duty   = pump_out_q;
	assign mode        = mode_out_q;
	assign power_led   = (mode_out_q != espc_pkg::MODE_OFF);
	assign ready_lamp  = (mode_out_q == espc_pkg::MODE_READY) ||
	                     (mode_out_q == espc_pkg::MODE_BREWING);

endmodule

>>> rtl/espc_checker.sv
// Port-level checks for the espresso controller, bound to the top level.
`timescale 1ns / 1ps

module espc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [espc_pkg::DUTY_W-1:0]       heater_duty,
	input logic [espc_pkg::DUTY_W-1:0]       pump_duty,
	input logic                              power_led,
	input logic                              ready_lamp,
	input logic [espc_pkg::MODE_W-1:0]       mode
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(heater_duty) &&
		$stable(pump_duty) && $stable(mode))
		else $error("result changed while stalled");

	// LEDs follow the reported mode
	a_leds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (power_led == (mode != espc_pkg::MODE_OFF)) &&
		(ready_lamp == ((mode == espc_pkg::MODE_READY) ||
		                (mode == espc_pkg::MODE_BREWING))))
		else $error("LEDs disagree with mode");

	// Duties stay within percent range
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (heater_duty <= espc_pkg::DUTY_MAX) &&
		(pump_duty <= espc_pkg::DUTY_MAX))
		else $error("duty above 100 percent");

	// Pump only runs while brewing
	a_pump_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode != espc_pkg::MODE_BREWING) |-> pump_duty == '0)
		else $error("pump running outside brewing");

	// Heater off when switched off
	a_heater_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (mode == espc_pkg::MODE_OFF) |-> heater_duty == '0)
		else $error("heater running while off");

endmodule

bind espresso_mode_and_pid_controller espc_checker u_espc_checker (.*);
